/* rtl/ptt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants for the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ADD_PER  = 2'd1;
  localparam logic [1:0] CMD_ADD_ONCE = 2'd2;
  localparam logic [1:0] CMD_REMOVE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [7:0]         id;
    logic [15:0]        interval;
    logic signed [31:0] countdown;
    logic               one_shot;
    logic               fresh;
  } entry_t;

  typedef struct packed {
    logic [7:0] task_id;
    logic       fired;
    logic       late;
    logic [1:0] status;
  } result_t;

endpackage
`default_nettype wire

/* rtl/periodic_task_timer_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_timer_table_core
// Ordered list of task timers held in a one-port-read, one-port-write memory.
// Add writes one entry; remove and tick walk the list one entry per cycle
// through the memory read port, rewriting and compacting behind the read,
// except while a firing report is held off by the result side.
// An add result goes through the pending and then the output register; a
// remove result or the last tick report is likewise flushed from the pending
// register to the output once the walk ends.
// A new command is taken only in idle; in_stall holds off the next one until
// the current command is done.
// Reset clears the state, the entry count and the valid flags; no memory clearing.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_core #(
  parameter int unsigned NUM_TASKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [15:0] in_interval,
  input  wire logic [15:0] in_elapsed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_task_id_res,
  output logic             out_fired,
  output logic             out_late,
  output logic [1:0]       out_status,
  output logic             out_last
);

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_TASKS + 1);
  localparam int unsigned RW    = ptt_pkg::RES_CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  ptt_pkg::entry_t mem [NUM_TASKS];
  ptt_pkg::entry_t rd_data_r;
  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr;
  ptt_pkg::entry_t wr_data;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] wr_idx_r, wr_idx_nxt;
  logic             proc_valid_r, proc_valid_nxt;
  logic             found_r, found_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [15:0]      el_r, el_nxt;
  logic [RW-1:0]    n_r, n_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  ptt_pkg::result_t pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  ptt_pkg::result_t out_res_r, out_res_nxt;
  logic             out_last_r, out_last_nxt;

  logic               out_free;
  logic               fire;
  logic signed [31:0] c_add;
  logic signed [31:0] c_mid;
  logic signed [32:0] c_sub;
  logic signed [31:0] c_new;
  logic               late;
  logic               emit;
  logic               stall_walk;
  ptt_pkg::entry_t    upd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    fire  = rd_data_r.countdown[31] || (rd_data_r.countdown == 32'sd0);
    c_add = rd_data_r.countdown + $signed({16'd0, rd_data_r.interval});
    if (!fire) begin
      c_mid = rd_data_r.countdown;
    end else if (rd_data_r.fresh) begin
      c_mid = 32'sd0;
    end else begin
      c_mid = c_add;
    end
    late  = c_mid[31];
    c_sub = {c_mid[31], c_mid} - $signed({17'd0, el_r});
    if (c_sub[32] && !c_sub[31]) begin
      c_new = 32'sh8000_0000;
    end else begin
      c_new = c_sub[31:0];
    end
    upd           = rd_data_r;
    upd.countdown = c_new;
    if (fire) begin
      upd.fresh = 1'b0;
    end
  end

  assign emit       = proc_valid_r && (cmd_r == ptt_pkg::CMD_TICK) && fire &&
                      (n_r < RW'(ptt_pkg::MAX_RESULTS));
  assign stall_walk = emit && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    proc_valid_nxt = proc_valid_r;
    found_nxt      = found_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    el_nxt         = el_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_res_nxt    = out_res_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = wr_idx_r[IDX_W-1:0];
    wr_data        = upd;
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          id_nxt     = in_task_id;
          el_nxt     = in_elapsed;
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          found_nxt  = 1'b0;
          n_nxt      = '0;
          proc_valid_nxt = 1'b0;
          if (in_command inside {ptt_pkg::CMD_ADD_PER, ptt_pkg::CMD_ADD_ONCE}) begin
            pend_valid_nxt   = 1'b1;
            pend_nxt.task_id = in_task_id;
            pend_nxt.fired   = 1'b0;
            pend_nxt.late    = 1'b0;
            if (count_r >= CNT_W'(NUM_TASKS)) begin
              pend_nxt.status = ptt_pkg::ST_FULL;
            end else begin
              pend_nxt.status     = ptt_pkg::ST_OK;
              wr_en               = 1'b1;
              wr_addr             = count_r[IDX_W-1:0];
              wr_data.id          = in_task_id;
              wr_data.interval    = in_interval;
              wr_data.countdown   = $signed({16'd0, in_interval});
              wr_data.one_shot    = (in_command == ptt_pkg::CMD_ADD_ONCE);
              wr_data.fresh       = 1'b1;
              count_nxt           = count_r + CNT_W'(1);
            end
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (!stall_walk) begin
          if (rd_idx_r < count_r) begin
            rd_en          = 1'b1;
            rd_idx_nxt     = rd_idx_r + CNT_W'(1);
            proc_valid_nxt = 1'b1;
          end else begin
            proc_valid_nxt = 1'b0;
          end

          if (proc_valid_r) begin
            if (cmd_r == ptt_pkg::CMD_REMOVE) begin
              if (!found_r && rd_data_r.id == id_r) begin
                found_nxt = 1'b1;
              end else begin
                wr_en      = 1'b1;
                wr_data    = rd_data_r;
                wr_idx_nxt = wr_idx_r + CNT_W'(1);
              end
            end else begin
              if (!(fire && rd_data_r.one_shot)) begin
                wr_en      = 1'b1;
                wr_idx_nxt = wr_idx_r + CNT_W'(1);
              end
              if (emit) begin
                if (pend_valid_r) begin
                  out_valid_nxt = 1'b1;
                  out_res_nxt   = pend_r;
                  out_last_nxt  = 1'b0;
                end
                pend_valid_nxt   = 1'b1;
                pend_nxt.task_id = rd_data_r.id;
                pend_nxt.fired   = 1'b1;
                pend_nxt.late    = late;
                pend_nxt.status  = ptt_pkg::ST_OK;
                n_nxt            = n_r + RW'(1);
              end
            end
          end else if (rd_idx_r >= count_r) begin
            count_nxt = wr_idx_r;
            if (cmd_r == ptt_pkg::CMD_REMOVE) begin
              pend_valid_nxt   = 1'b1;
              pend_nxt.task_id = id_r;
              pend_nxt.fired   = 1'b0;
              pend_nxt.late    = 1'b0;
              pend_nxt.status  = found_r ? ptt_pkg::ST_OK : ptt_pkg::ST_NOT_FOUND;
              state_nxt        = S_FLUSH;
            end else begin
              state_nxt = pend_valid_r ? S_FLUSH : S_IDLE;
            end
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_res_nxt    = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      proc_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      proc_valid_r <= proc_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    found_r    <= found_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    el_r       <= el_nxt;
    n_r        <= n_nxt;
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_task_id_res = out_res_r.task_id;
  assign out_fired       = out_res_r.fired;
  assign out_late        = out_res_r.late;
  assign out_status      = out_res_r.status;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire
